/* rtl/spe_pkg.sv */
package spe_pkg;

  localparam int MAX_DEGREE_DEF = 7;
  localparam int CFG_W          = 3;
  localparam logic [CFG_W-1:0] DEGREE_RESET = 3'd7;
  localparam int IDX_W          = 6;
  localparam int COEF_W         = 32;
  localparam int COORD_W        = 16;
  localparam int VALUE_W        = 48;
  localparam int FRAC           = 30;
  localparam int Z_W            = 31;
  localparam int SQRT_STEPS     = 31;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Round half up, then drop FRAC fraction bits.
  function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v + 64'sd536870912) >>> FRAC;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] s;
    s = (v + 48'sd16384) >>> 15;
    return s[31:0];
  endfunction

endpackage

/* rtl/sphere_polynomial_eval_top.sv */
// Load transaction: written straight into the store, busy stays low, no result.
// Evaluate transaction for active degree d: x^2 + y^2 is formed, then the bit-serial
// square root is launched and run (powers of x and y are built alongside), then one
// coefficient read and term per cycle for the (d+1)^2 terms, then the term pipeline drains.
// One result strobe per evaluate, which the receiver cannot stall; busy is high until then.
// Synchronous active-low reset clears control and sets degree_used to 7; the store is not cleared.
module sphere_polynomial_eval_top #(
  parameter int MAX_DEGREE = spe_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [spe_pkg::IDX_W-1:0]           in_coeff_index,
  input  logic signed [spe_pkg::COEF_W-1:0]   in_coeff_value,
  input  logic signed [spe_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [spe_pkg::COORD_W-1:0]  in_y_coord,
  output logic                                out_strobe,
  output logic signed [spe_pkg::VALUE_W-1:0]  out_value,
  output logic                                out_off_disk,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spe_pkg::CFG_W-1:0]           cfg_degree_used
);
  import spe_pkg::*;

  localparam int NP    = MAX_DEGREE + 1;
  localparam int DEPTH = NP * NP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (NP > 1) ? $clog2(NP) : 1;
  localparam int KW    = $clog2(NP + 1);
  localparam int ACC_W = COEF_W + AW + 2;

  typedef enum logic [2:0] {S_IDLE, S_R2, S_SQST, S_SQ, S_RUN, S_DRAIN} state_t;

  state_t state_r;
  logic [CFG_W-1:0] degree_used_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [32:0] r2_r;
  logic off_r;
  logic [KW-1:0] k_r;
  logic signed [31:0] px_r [NP];
  logic signed [31:0] py_r [NP];
  logic [LW-1:0] l_r;
  logic [LW:0] nu_r;
  logic [AW-1:0] n_r;
  logic [LW-1:0] deg;
  logic [LW:0] two_l;
  logic [LW:0] mu;
  logic last;
  logic [KW-1:0] k_prev;
  logic [LW-1:0] kp_idx, kw_idx;
  logic sq_start, sq_busy;
  logic [Z_W-1:0] z, radicand;
  logic mem_we;
  logic [COEF_W-1:0] mem_rdata;
  logic [5:0] v_r;
  logic signed [63:0] p_r, m2_r, c_r;
  logic signed [31:0] t1_r, t2_r, coef1_r, coef2_r, coef3_r;
  logic odd0_r, odd1_r;
  logic signed [31:0] zsel;
  logic signed [63:0] c_rnd;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0] acc_ext;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -(64'sd1 <<< (VALUE_W - 1));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign deg    = (int'(degree_used_r) > MAX_DEGREE) ? LW'(MAX_DEGREE) : LW'(degree_used_r);
  assign two_l  = {l_r, 1'b0};
  assign mu     = two_l - nu_r;
  assign last   = (l_r == deg) && (nu_r == two_l);
  assign k_prev = k_r - 1'b1;
  assign kp_idx = k_prev[LW-1:0];
  assign kw_idx = k_r[LW-1:0];

  // Loads go straight into the store; indexes beyond it are dropped.
  assign mem_we = start && !busy && !in_mode && (int'(in_coeff_index) < DEPTH);

  spe_coef_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COEF_W)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (AW'(in_coeff_index)),
    .wdata   (in_coeff_value),
    .raddr   (n_r),
    .rdata_r (mem_rdata)
  );

  assign sq_start = (state_r == S_SQST);
  assign radicand = (r2_r > 33'h0_4000_0000) ? '0 : Z_W'(33'h0_4000_0000 - r2_r);

  spe_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_used_r <= DEGREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      degree_used_r <= cfg_degree_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
      v_r        <= '0;
    end else begin
      out_strobe <= 1'b0;
      v_r        <= {v_r[4:0], (state_r == S_RUN)};
      unique case (state_r)
        S_IDLE: begin
          if (start && in_mode) begin
            x_r     <= in_x_coord;
            y_r     <= in_y_coord;
            state_r <= S_R2;
          end
        end
        S_R2: begin
          r2_r    <= 33'(32'(x_r * x_r)) + 33'(32'(y_r * y_r));
          state_r <= S_SQST;
        end
        S_SQST: begin
          off_r    <= r2_r > 33'h0_4000_0000;
          px_r[0]  <= ONE_Q30;
          py_r[0]  <= ONE_Q30;
          k_r      <= KW'(1);
          state_r  <= S_SQ;
        end
        S_SQ: begin
          if (int'(k_r) <= MAX_DEGREE) begin
            px_r[kw_idx] <= rnd15(48'(px_r[kp_idx] * x_r));
            py_r[kw_idx] <= rnd15(48'(py_r[kp_idx] * y_r));
            k_r          <= k_r + 1'b1;
          end else if (!sq_busy) begin
            l_r     <= '0;
            nu_r    <= '0;
            n_r     <= '0;
            acc_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          n_r <= n_r + 1'b1;
          if (last) begin
            state_r <= S_DRAIN;
          end else if (nu_r == two_l) begin
            nu_r <= '0;
            l_r  <= l_r + 1'b1;
          end else begin
            nu_r <= nu_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (v_r == '0) begin
            out_strobe    <= 1'b1;
            out_off_disk  <= off_r;
            if (acc_ext > VMAX) begin
              out_value     <= VALUE_W'(VMAX);
              out_saturated <= 1'b1;
            end else if (acc_ext < VMIN) begin
              out_value     <= VALUE_W'(VMIN);
              out_saturated <= 1'b1;
            end else begin
              out_value     <= VALUE_W'(acc_ext);
              out_saturated <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (v_r[4]) begin
        acc_r <= acc_r + ACC_W'(c_rnd);
      end
    end
  end

  // Term pipeline: x^a y^b, then times z (or one), then times the coefficient.
  assign zsel    = odd1_r ? 32'(z) : ONE_Q30;
  assign c_rnd   = (c_r + 64'sd536870912) >>> FRAC;
  assign acc_ext = 64'(acc_r);

  always_ff @(posedge clk) begin
    p_r     <= px_r[mu[LW:1]] * py_r[nu_r[LW:1]];
    odd0_r  <= nu_r[0];
    t1_r    <= rnd30(p_r);
    odd1_r  <= odd0_r;
    coef1_r <= mem_rdata;
    m2_r    <= t1_r * zsel;
    coef2_r <= coef1_r;
    t2_r    <= rnd30(m2_r);
    coef3_r <= coef2_r;
    c_r     <= coef3_r * t2_r;
  end

endmodule

/* rtl/spe_coef_mem.sv */
module spe_coef_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/spe_sqrt.sv */
module spe_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [spe_pkg::Z_W-1:0]  radicand,
  output logic                     busy,
  output logic [spe_pkg::Z_W-1:0]  root
);
  import spe_pkg::*;

  localparam int CW = $clog2(SQRT_STEPS + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [61:0]   v_r;
  logic [32:0]   rem_r;
  logic [30:0]   q_r;
  logic [34:0]   sh;
  logic [34:0]   trial;
  logic          ge;
  logic [34:0]   diff;

  // One result bit per cycle, two radicand bits brought down each step.
  assign sh    = {rem_r[32:0], v_r[61:60]};
  assign trial = {2'b00, q_r, 2'b01};
  assign ge    = sh >= trial;
  assign diff  = sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(SQRT_STEPS);
      // The Q30 radicand is scaled by 2^30 so that the root comes out in Q30.
      v_r    <= {1'b0, radicand, 30'b0};
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[32:0] : sh[32:0];
      q_r    <= {q_r[29:0], ge};
      v_r    <= {v_r[59:0], 2'b00};
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = q_r;

endmodule

/* rtl/spe_checker.sv */
module spe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                in_mode,
  input logic                                out_strobe,
  input logic signed [spe_pkg::VALUE_W-1:0]  out_value,
  input logic                                out_saturated
);
  import spe_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result strobe while busy");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> (!busy && !out_strobe))
    else $error("load transaction made the block busy");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy) else $error("evaluate not started");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |->
      (out_value == {1'b0, {(VALUE_W-1){1'b1}}} || out_value == {1'b1, {(VALUE_W-1){1'b0}}}))
    else $error("saturated result not at a range limit");

endmodule

bind sphere_polynomial_eval_top spe_checker u_spe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_strobe    (out_strobe),
  .out_value     (out_value),
  .out_saturated (out_saturated)
);

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import spe_pkg::*;

  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_EVAL = 1'b1;
  localparam int STORE_DEPTH = (MAX_DEGREE_DEF + 1) * (MAX_DEGREE_DEF + 1);
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic {TX_INPUT, TX_CFG} tx_kind_t;

  typedef struct {
    tx_kind_t              kind;
    logic                  mode;
    logic [IDX_W-1:0]      idx;
    logic [COEF_W-1:0]     coef;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [CFG_W-1:0]      degree;
  } pending_tx_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               off_disk;
    logic               saturated;
  } sphere_value_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [IDX_W-1:0] in_coeff_index = '0;
  logic signed [COEF_W-1:0] in_coeff_value = '0;
  logic signed [COORD_W-1:0] in_x_coord = '0;
  logic signed [COORD_W-1:0] in_y_coord = '0;
  logic out_strobe;
  logic signed [VALUE_W-1:0] out_value;
  logic out_off_disk;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_degree_used = '0;

  pending_tx_t   pending_q[$];
  sphere_value_t expected_values[$];
  logic signed [COEF_W-1:0] coeff_copy[STORE_DEPTH];
  int unsigned active_degree = DEGREE_RESET;
  int mismatches = 0;
  int results_seen = 0;
  int evals_sent = 0;
  int loads_sent = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  int cycle_count = 0;

  sphere_polynomial_eval_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .out_strobe(out_strobe), .out_value(out_value),
    .out_off_disk(out_off_disk), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_degree_used(cfg_degree_used)
  );

  always #2 clk = ~clk;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic sphere_value_t sphere_sum(logic signed [COORD_W-1:0] xc,
                                               logic signed [COORD_W-1:0] yc);
    sphere_value_t res;
    longint xs, ys, r2, z, acc, term;
    longint px[MAX_DEGREE_DEF+1];
    longint py[MAX_DEGREE_DEF+1];
    int deg, n, mu, nu;
    xs = xc;
    ys = yc;
    deg = (active_degree < MAX_DEGREE_DEF) ? active_degree : MAX_DEGREE_DEF;
    res.off_disk = 1'b0;
    res.saturated = 1'b0;
    r2 = xs * xs + ys * ys;
    if (r2 > (longint'(1) << 30)) begin
      res.off_disk = 1'b1;
      z = 0;
    end else begin
      z = longint'(int_sqrt(longint'(((longint'(1) << 30) - r2) << 30)));
    end
    px[0] = longint'(1) << 30;
    py[0] = longint'(1) << 30;
    for (int k = 1; k <= MAX_DEGREE_DEF; k++) begin
      px[k] = round_shift(px[k-1] * xs, 15);
      py[k] = round_shift(py[k-1] * ys, 15);
    end
    acc = 0;
    n = 0;
    for (int l = 0; l <= deg; l++) begin
      for (int m = -l; m <= l; m++) begin
        mu = l - m;
        nu = l + m;
        if (nu % 2 == 0) begin
          term = round_shift(px[mu/2] * py[nu/2], 30);
        end else begin
          term = round_shift(px[(mu-1)/2] * py[(nu-1)/2], 30);
          term = round_shift(term * z, 30);
        end
        acc += round_shift(longint'(coeff_copy[n]) * term, 30);
        n++;
      end
    end
    if (acc > (longint'(1) <<< 47) - 1) begin
      acc = (longint'(1) <<< 47) - 1;
      res.saturated = 1'b1;
    end
    if (acc < -(longint'(1) <<< 47)) begin
      acc = -(longint'(1) <<< 47);
      res.saturated = 1'b1;
    end
    res.value = acc[VALUE_W-1:0];
    return res;
  endfunction

  function automatic void push_load(int idx, logic [COEF_W-1:0] val);
    pending_tx_t t;
    t = '{kind: TX_INPUT, mode: MODE_LOAD, idx: IDX_W'(idx), coef: val,
          x: COORD_W'($urandom), y: COORD_W'($urandom), degree: '0};
    pending_q.push_back(t);
  endfunction

  function automatic void push_eval(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    pending_tx_t t;
    t = '{kind: TX_INPUT, mode: MODE_EVAL, idx: IDX_W'($urandom), coef: $urandom,
          x: x, y: y, degree: '0};
    pending_q.push_back(t);
  endfunction

  function automatic void push_cfg(int d);
    pending_tx_t t;
    t = '{kind: TX_CFG, mode: MODE_LOAD, idx: '0, coef: '0, x: '0, y: '0,
          degree: CFG_W'(d)};
    pending_q.push_back(t);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord(int pick);
    logic [COORD_W-1:0] c;
    c = COORD_W'($urandom);
    case (pick)
      0: c = 16'h8000;
      1: c = 16'h7fff;
      2: c = 16'h0000;
      3, 4, 5, 6: c = {c[COORD_W-1], c[COORD_W-1:1]};
      default: ;
    endcase
    return c;
  endfunction

  // Driver: one pending transaction is presented at a time.
  always @(posedge clk) begin
    pending_tx_t head;
    logic next_start;
    logic next_cfg;
    bit no_idle;
    next_start = 1'b0;
    next_cfg = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (start && !busy) begin
        head = pending_q.pop_front();
        if (head.mode == MODE_LOAD) begin
          if (head.idx < STORE_DEPTH) coeff_copy[head.idx] = head.coef;
          loads_sent++;
        end else begin
          expected_values.push_back(sphere_sum(head.x, head.y));
          evals_sent++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        head = pending_q.pop_front();
        active_degree = head.degree;
        cfg_writes++;
      end
      if (expected_values.size() == 0 && !busy) quiet_cycles++;
      else quiet_cycles = 0;
      no_idle = (loads_sent + evals_sent >= 450) && (loads_sent + evals_sent < 650);
      if (pending_q.size() > 0) begin
        head = pending_q[0];
        if (head.kind == TX_CFG) begin
          if (quiet_cycles >= SETTLE_CYCLES) next_cfg = 1'b1;
        end else if (no_idle || $urandom_range(99) >= 20) begin
          next_start = 1'b1;
        end
        in_mode <= head.mode;
        in_coeff_index <= head.idx;
        in_coeff_value <= head.coef;
        in_x_coord <= head.x;
        in_y_coord <= head.y;
        cfg_degree_used <= head.degree;
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // Monitor: every strobe must match the oldest expected value.
  always @(posedge clk) begin
    sphere_value_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: value=%h off_disk=%b saturated=%b",
                   out_value, out_off_disk, out_saturated);
      end else begin
        want = expected_values.pop_front();
        if (out_value !== want.value || out_off_disk !== want.off_disk ||
            out_saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected value=%h off=%b sat=%b, got value=%h off=%b sat=%b",
                     results_seen, want.value, want.off_disk, want.saturated,
                     out_value, out_off_disk, out_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int degrees[8];
    int phase_len;
    degrees = '{7, 0, 3, 1, 5, 2, 6, 4};
    // Every entry is written before the first evaluate reads it.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i == 0) push_load(i, 32'h7fff_ffff);
      else if (i == STORE_DEPTH - 1) push_load(i, 32'h8000_0000);
      else push_load(i, $urandom);
    end
    push_eval(16'h0000, 16'h0000);
    push_eval(16'h8000, 16'h0000);
    push_eval(16'h0000, 16'h8000);
    push_eval(16'h7fff, 16'h0000);
    push_eval(16'h7fff, 16'h7fff);
    push_eval(16'h8000, 16'h8000);
    push_eval(16'd23170, 16'd23170);
    push_eval(16'd23171, 16'd23171);
    push_eval(16'h8001, 16'h7fff);
    push_load(STORE_DEPTH - 1, 32'h7fff_ffff);
    push_load(0, 32'h8000_0000);
    push_eval(16'h4000, 16'hc000);
    push_eval(16'h0001, 16'hffff);
    for (int p = 0; p < 10; p++) begin
      if (p == 8) push_cfg(7);
      else if (p == 9) push_cfg(0);
      else if (p > 0) push_cfg(degrees[p]);
      phase_len = (p == 0) ? 190 : 90;
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(99) < 35) push_load($urandom_range(STORE_DEPTH - 1), $urandom);
        else push_eval(random_coord($urandom_range(15)), random_coord($urandom_range(15)));
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && expected_values.size() == 0);
    repeat (120) @(posedge clk);
    if (expected_values.size() != 0) mismatches += expected_values.size();
    $display("Ran %0d loads and %0d evaluates, checked %0d results.",
             loads_sent, evals_sent, results_seen);
    $display("Degree register written %0d times, including both extremes.", cfg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
